// ===== rtl/twgr_pkg.sv =====
// ----------------------------------------------------------------------------
// twgr_pkg: shared types and constants for the touch wake gesture recognizer
// Fixed screen geometry, gesture codes, register indexes and channel structs.
// ----------------------------------------------------------------------------
package twgr_pkg;

  localparam int unsigned CW = 12;
  localparam int unsigned TW = 32;

  // screen geometry
  localparam int unsigned Y_MAX   = 2559;
  localparam int unsigned X_MAX   = 1439;
  localparam int unsigned EDGE    = 130;
  localparam int unsigned Y_LIMIT = Y_MAX - EDGE;
  localparam int unsigned X_LIMIT = X_MAX - EDGE;
  localparam int unsigned X_B1    = 532;
  localparam int unsigned X_B2    = 960;
  localparam int unsigned Y_START = 1066;
  localparam int unsigned X_START = 720;
  localparam int unsigned X_FINAL = 360;
  localparam int unsigned Y_NEXT  = 180;

  // request types
  localparam logic [2:0] REQ_SLOT = 3'd0;
  localparam logic [2:0] REQ_LIFT = 3'd1;
  localparam logic [2:0] REQ_X    = 3'd2;
  localparam logic [2:0] REQ_Y    = 3'd3;

  // gesture codes
  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] CODE_RIGHT = 3'd1;
  localparam logic [2:0] CODE_LEFT  = 3'd2;
  localparam logic [2:0] CODE_UP    = 3'd3;
  localparam logic [2:0] CODE_DOWN  = 3'd4;
  localparam logic [2:0] CODE_DTAP  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_WAKE    = 3'd0;
  localparam logic [2:0] REG_SLEEP   = 3'd1;
  localparam logic [2:0] REG_TAPMODE = 3'd2;
  localparam logic [2:0] REG_REPORT  = 3'd3;
  localparam logic [2:0] REG_RADIUS  = 3'd4;
  localparam logic [2:0] REG_WINDOW  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT = 3'd6;
  localparam logic [2:0] REG_HOLDOFF = 3'd7;

  localparam logic [1:0] TAP_SCREEN_OFF = 2'd1;
  localparam logic [1:0] TAP_ALWAYS     = 2'd2;

  typedef struct packed {
    logic [3:0]  wake_mask;
    logic [1:0]  sleep_mask;
    logic [1:0]  tap_mode;
    logic        report_en;
    logic [11:0] radius;
    logic [15:0] window_ms;
    logic [15:0] timeout;
    logic [15:0] holdoff;
  } cfg_t;

  typedef struct packed {
    logic [2:0]    req_type;
    logic [CW-1:0] coord_value;
    logic          screen_off;
    logic [TW-1:0] now_ms;
    logic [TW-1:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic       report_valid;
    logic [2:0] report_code;
    logic       power_press;
  } rsp_t;

  // classified command from front to back
  typedef struct packed {
    logic          slot;
    logic          lift;
    logic          run;
    logic          off;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [TW-1:0] now_ms;
    logic [TW-1:0] now_ticks;
  } cmd_t;

endpackage

// ===== rtl/twgr_if.sv =====
// ----------------------------------------------------------------------------
// twgr_req_if / twgr_rsp_if: valid/ready channels
// Request and result channels with source and sink views.
// ----------------------------------------------------------------------------
interface twgr_req_if;
  logic             valid;
  logic             ready;
  twgr_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface twgr_rsp_if;
  logic             valid;
  logic             ready;
  twgr_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/twgr_front.sv =====
// ----------------------------------------------------------------------------
// twgr_front: coordinate latch and X/Y pairing
// Accepts items, latches coordinates and decides whether sweep logic runs.
// ----------------------------------------------------------------------------
module twgr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  twgr_pkg::req_t     in_item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output twgr_pkg::cmd_t     cmd
);
  import twgr_pkg::*;

  logic [CW-1:0] latest_x, latest_y;
  logic          x_seen, y_seen;
  logic [CW-1:0] x_new, y_new;
  logic          xs_new, ys_new, run;
  logic          fire;

  assign in_ready = cmd_ready;
  assign cmd_valid = in_valid;
  assign fire = in_valid && cmd_ready;

  // pairing decision
  always_comb begin
    x_new  = latest_x;
    y_new  = latest_y;
    xs_new = x_seen;
    ys_new = y_seen;
    run    = 1'b0;
    if (in_item.req_type != REQ_SLOT && in_item.req_type != REQ_LIFT) begin
      if (in_item.req_type == REQ_X) begin
        x_new  = in_item.coord_value;
        xs_new = 1'b1;
      end else if (in_item.req_type == REQ_Y) begin
        y_new  = in_item.coord_value;
        ys_new = 1'b1;
      end
      run = (xs_new && ys_new) || (!in_item.screen_off && xs_new && !ys_new);
      if (run) begin
        xs_new = 1'b0;
        ys_new = 1'b0;
      end
    end
  end

  always_comb begin
    cmd.slot      = in_item.req_type == REQ_SLOT;
    cmd.lift      = in_item.req_type == REQ_LIFT;
    cmd.run       = run;
    cmd.off       = in_item.screen_off;
    cmd.x         = x_new;
    cmd.y         = y_new;
    cmd.now_ms    = in_item.now_ms;
    cmd.now_ticks = in_item.now_ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest_x <= '0;
      latest_y <= '0;
      x_seen   <= 1'b0;
      y_seen   <= 1'b0;
    end else if (fire) begin
      latest_x <= x_new;
      latest_y <= y_new;
      x_seen   <= xs_new;
      y_seen   <= ys_new;
    end
  end

endmodule

// ===== rtl/twgr_queue.sv =====
// ----------------------------------------------------------------------------
// twgr_queue: two-entry command queue
// Decouples the front from the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module twgr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  twgr_pkg::cmd_t   in_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output twgr_pkg::cmd_t   out_cmd
);
  import twgr_pkg::*;

  cmd_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_cmd   = mem[rptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |=> count == 2'd2)
    else $error("queue lost an entry");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_push: assert property (@(posedge clk) disable iff (rst)
    push && pop |=> $stable(count))
    else $error("queue count moved on push and pop");

endmodule

// ===== rtl/twgr_back.sv =====
// ----------------------------------------------------------------------------
// twgr_back: sweep, double tap and holdoff engine
// Runs one command per cycle, unless stalled, into a registered result stage.
// ----------------------------------------------------------------------------
module twgr_back (
  input  logic             clk,
  input  logic             rst,
  input  twgr_pkg::cfg_t   cfg,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  twgr_pkg::cmd_t   cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output twgr_pkg::rsp_t   out_rsp
);
  import twgr_pkg::*;

  logic [CW-1:0] sx, sy;
  logic [TW-1:0] sx_tick, sy_tick;
  logic [1:0]    xb, yb;
  logic          x_armed, y_armed;
  logic [1:0]    tap_count;
  logic [TW-1:0] tap_ms;
  logic [CW-1:0] tap_x, tap_y;
  logic          tap_armed, fresh;
  logic [TW-1:0] att0, att1;

  logic [CW-1:0] sx_next, sy_next;
  logic [TW-1:0] sx_tick_next, sy_tick_next;
  logic [1:0]    xb_next, yb_next;
  logic          x_armed_next, y_armed_next;
  logic [1:0]    tap_count_next;
  logic [TW-1:0] tap_ms_next;
  logic [CW-1:0] tap_x_next, tap_y_next;
  logic          tap_armed_next, fresh_next;
  logic [TW-1:0] att0_next, att1_next;
  rsp_t          rsp;
  logic          fire;

  assign cmd_ready = !out_valid || out_ready;
  assign fire = cmd_valid && cmd_ready;

  // signed 15-bit coordinates for start-relative bounds
  logic signed [CW+2:0] y, s;
  logic                 en0, en1, v_up, v_dn, tmo_x, tmo_y, mode_ok;
  logic [CW-1:0]        dx, dy;
  logic [TW-1:0]        dt;

  always_comb begin
    sx_next = sx; sy_next = sy; sx_tick_next = sx_tick; sy_tick_next = sy_tick;
    xb_next = xb; yb_next = yb; x_armed_next = x_armed; y_armed_next = y_armed;
    tap_count_next = tap_count; tap_ms_next = tap_ms; tap_x_next = tap_x;
    tap_y_next = tap_y; tap_armed_next = tap_armed; fresh_next = fresh;
    att0_next = att0; att1_next = att1;
    rsp = '0;
    y = $signed({3'b000, cmd.y});
    s = '0;
    en0 = 1'b0; en1 = 1'b0; v_up = 1'b0; v_dn = 1'b0;
    tmo_x = 1'b0; tmo_y = 1'b0; mode_ok = 1'b0;
    dx = '0; dy = '0; dt = '0;

    if (cmd.slot || cmd.lift) begin
      x_armed_next = 1'b1; xb_next = '0; sx_next = '0; sx_tick_next = '0;
      y_armed_next = 1'b1; yb_next = '0; sy_next = '0; sy_tick_next = '0;
    end
    if (cmd.slot) begin
      tap_armed_next = 1'b1; tap_count_next = '0; tap_ms_next = '0;
      tap_x_next = '0; tap_y_next = '0;
    end else if (cmd.lift) begin
      fresh_next = 1'b1;
      mode_ok = (cfg.tap_mode == TAP_SCREEN_OFF && cmd.off) || cfg.tap_mode == TAP_ALWAYS;
      if (!(cmd.x < CW'(EDGE) || cmd.x > CW'(X_LIMIT) || cmd.y < CW'(EDGE)
            || cmd.y > CW'(Y_LIMIT)) && mode_ok && tap_armed) begin
        fresh_next = 1'b0;
        dx = (cmd.x > tap_x) ? cmd.x - tap_x : tap_x - cmd.x;
        dy = (cmd.y > tap_y) ? cmd.y - tap_y : tap_y - cmd.y;
        dt = cmd.now_ms - tap_ms;
        if (tap_count == 2'd1 && dx < cfg.radius && dy < cfg.radius
            && dt < TW'(cfg.window_ms)) begin
          // second tap hit; tap state clears and re-arms
          tap_count_next = '0; tap_ms_next = '0; tap_x_next = '0; tap_y_next = '0;
          if (cfg.report_en) begin
            att1_next = att0;
            att0_next = cmd.now_ticks;
            if (!(cmd.now_ticks - att0 < TW'(cfg.holdoff))) begin
              rsp.report_valid = 1'b1;
              rsp.report_code  = CODE_DTAP;
            end
          end else begin
            rsp.power_press = 1'b1;
          end
        end else begin
          tap_count_next = 2'd1;
          tap_ms_next = cmd.now_ms;
          tap_x_next = cmd.x;
          tap_y_next = cmd.y;
        end
      end
    end else if (cmd.run) begin
      // horizontal sweep
      en0 = cmd.off ? cfg.wake_mask[0] : cfg.sleep_mask[0];
      en1 = cmd.off ? cfg.wake_mask[1] : cfg.sleep_mask[1];
      if (!cmd.off && cmd.y < CW'(Y_LIMIT)) begin
        x_armed_next = 1'b1; xb_next = '0; sx_next = '0; sx_tick_next = '0;
        y_armed_next = 1'b1; yb_next = '0; sy_next = '0; sy_tick_next = '0;
      end else begin
        if (sx == '0) begin
          sx_next = cmd.x;
          sx_tick_next = cmd.now_ticks;
        end
        tmo_x = (cmd.now_ticks - sx_tick_next) < TW'(cfg.timeout);
        if (sx_next < CW'(X_START) && en0) begin
          if (xb[0] || (cmd.x > '0 && cmd.x < CW'(X_B1))) begin
            xb_next[0] = 1'b1;
            if (xb[1] || (cmd.x > CW'(X_B1) && cmd.x < CW'(X_B2))) begin
              xb_next[1] = 1'b1;
              if (cmd.x > CW'(X_B2) && cmd.x > CW'(X_MAX - X_FINAL) && x_armed && tmo_x) begin
                rsp.power_press = 1'b1;
                x_armed_next = 1'b0;
                if (cfg.report_en && cmd.off) begin
                  att1_next = att0;
                  att0_next = cmd.now_ticks;
                  if (!(cmd.now_ticks - att0 < TW'(cfg.holdoff))) begin
                    rsp.report_valid = 1'b1;
                    rsp.report_code = CODE_RIGHT;
                  end
                end
              end
            end
          end
        end else if (sx_next >= CW'(X_START) && en1) begin
          if (xb[0] || (cmd.x < CW'(X_MAX - X_FINAL) && cmd.x > CW'(X_B2))) begin
            xb_next[0] = 1'b1;
            if (xb[1] || (cmd.x < CW'(X_B2) && cmd.x > CW'(X_B1))) begin
              xb_next[1] = 1'b1;
              if (cmd.x < CW'(X_B1) && cmd.x < CW'(X_FINAL) && x_armed) begin
                rsp.power_press = 1'b1;
                x_armed_next = 1'b0;
                if (cfg.report_en && cmd.off) begin
                  att1_next = att0;
                  att0_next = cmd.now_ticks;
                  if (!(cmd.now_ticks - att0 < TW'(cfg.holdoff))) begin
                    rsp.report_valid = 1'b1;
                    rsp.report_code = CODE_LEFT;
                  end
                end
              end
            end
          end
        end
      end
      // vertical sweep, screen off only
      if (cmd.off) begin
        if (sy == '0) begin
          sy_next = cmd.y;
          sy_tick_next = cmd.now_ticks;
        end
        s = $signed({3'b000, sy_next});
        tmo_y = (cmd.now_ticks - sy_tick_next) < TW'(cfg.timeout);
        if (sy_next > CW'(Y_START) && cfg.wake_mask[2]) begin
          if (yb[0] || (y < s && y > s - 15'sd180)) begin
            yb_next[0] = 1'b1;
            if (yb[1] || (y < s - 15'sd180 && y > s - 15'sd360)) begin
              yb_next[1] = 1'b1;
              if (y < s - 15'sd540 && y_armed && tmo_y) v_up = 1'b1;
            end
          end
        end else if (sy_next <= CW'(Y_START) && cfg.wake_mask[3]) begin
          if (yb[0] || (y > s && y < s + 15'sd180)) begin
            yb_next[0] = 1'b1;
            if (yb[1] || (y > s + 15'sd180 && y < s + 15'sd360)) begin
              yb_next[1] = 1'b1;
              if (y > s + 15'sd540 && y_armed && tmo_y) v_dn = 1'b1;
            end
          end
        end
        if (v_up || v_dn) begin
          rsp.power_press = 1'b1;
          y_armed_next = 1'b0;
          if (cfg.report_en) begin
            att1_next = att0_next;
            att0_next = cmd.now_ticks;
            if (!(cmd.now_ticks - att1_next < TW'(cfg.holdoff)) && !rsp.report_valid) begin
              rsp.report_valid = 1'b1;
              rsp.report_code = v_up ? CODE_UP : CODE_DOWN;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; sx_tick <= '0; sy_tick <= '0;
      xb <= '0; yb <= '0; x_armed <= 1'b1; y_armed <= 1'b1;
      tap_count <= '0; tap_ms <= '0; tap_x <= '0; tap_y <= '0;
      tap_armed <= 1'b1; fresh <= 1'b1; att0 <= '0; att1 <= '0;
      out_valid <= 1'b0;
      out_rsp <= '0;
    end else begin
      if (fire) begin
        sx <= sx_next; sy <= sy_next; sx_tick <= sx_tick_next; sy_tick <= sy_tick_next;
        xb <= xb_next; yb <= yb_next; x_armed <= x_armed_next; y_armed <= y_armed_next;
        tap_count <= tap_count_next; tap_ms <= tap_ms_next; tap_x <= tap_x_next;
        tap_y <= tap_y_next; tap_armed <= tap_armed_next; fresh <= fresh_next;
        att0 <= att0_next; att1 <= att1_next;
        out_rsp <= rsp;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result dropped while stalled");
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.report_valid |-> out_rsp.report_code == CODE_NONE)
    else $error("code without report");
  a_tap_clear: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.slot |=> tap_count == 2'd0 && tap_armed)
    else $error("slot change did not clear taps");

endmodule

// ===== rtl/touch_wake_gesture_recognizer_core.sv =====
// Path: an accepted item is written into the queue and then registered in the
// result register, from which it can be taken.
// Throughput: one item per cycle unless the result register is stalled.
// Reset: synchronous rst clears all gesture state, the queue and the
// result register, and restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// touch_wake_gesture_recognizer_core: top level
// Register port, front classifier, command queue and gesture back end.
// ----------------------------------------------------------------------------
module touch_wake_gesture_recognizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  twgr_req_if.sink    req,
  twgr_rsp_if.source  rsp
);
  import twgr_pkg::*;

  cfg_t       cfg;
  logic [2:0] ridx;
  cmd_t       f_cmd, q_cmd;
  logic       f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{wake_mask: 4'd0, sleep_mask: 2'd0, tap_mode: 2'd0, report_en: 1'b0,
               radius: 12'd200, window_ms: 16'd700, timeout: 16'd30, holdoff: 16'd50};
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_WAKE:    cfg.wake_mask  <= pwdata[3:0];
        REG_SLEEP:   cfg.sleep_mask <= pwdata[1:0];
        REG_TAPMODE: cfg.tap_mode   <= pwdata[1:0];
        REG_REPORT:  cfg.report_en  <= pwdata[0];
        REG_RADIUS:  cfg.radius     <= pwdata[11:0];
        REG_WINDOW:  cfg.window_ms  <= pwdata[15:0];
        REG_TIMEOUT: cfg.timeout    <= pwdata[15:0];
        REG_HOLDOFF: cfg.holdoff    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_WAKE:    prdata = {28'd0, cfg.wake_mask};
      REG_SLEEP:   prdata = {30'd0, cfg.sleep_mask};
      REG_TAPMODE: prdata = {30'd0, cfg.tap_mode};
      REG_REPORT:  prdata = {31'd0, cfg.report_en};
      REG_RADIUS:  prdata = {20'd0, cfg.radius};
      REG_WINDOW:  prdata = {16'd0, cfg.window_ms};
      REG_TIMEOUT: prdata = {16'd0, cfg.timeout};
      REG_HOLDOFF: prdata = {16'd0, cfg.holdoff};
      default:     prdata = '0;
    endcase
  end

  twgr_front u_front (
    .clk, .rst,
    .in_valid (req.valid), .in_ready (req.ready), .in_item (req.payload),
    .cmd_valid (f_valid), .cmd_ready (f_ready), .cmd (f_cmd)
  );

  twgr_queue u_queue (
    .clk, .rst,
    .in_valid (f_valid), .in_ready (f_ready), .in_cmd (f_cmd),
    .out_valid (q_valid), .out_ready (q_ready), .out_cmd (q_cmd)
  );

  twgr_back u_back (
    .clk, .rst, .cfg,
    .cmd_valid (q_valid), .cmd_ready (q_ready), .cmd (q_cmd),
    .out_valid (rsp.valid), .out_ready (rsp.ready), .out_rsp (rsp.payload)
  );

endmodule
